// ===== hdl/ncd_pkg.sv =====
// ----------------------------------------------------------------------------
// ncd_pkg
// Shared types and constants for the negative cycle detector.
// ----------------------------------------------------------------------------
package ncd_pkg;

    localparam int MAX_NODES_DEF = 8;
    localparam int CFG_W         = 4;
    localparam int FIELD_NODE_W  = 3;
    localparam int WEIGHT_W      = 24;
    // 24-bit weights summed along at most a few hundred relaxations stay well inside 34 bits
    localparam int DIST_W        = 34;

    localparam logic [CFG_W-1:0] NODES_RESET = 4'd6;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_RUN  = 1'b1
    } op_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_ROW,
        ST_EDGE,
        ST_WALK,
        ST_EMIT,
        ST_NONE
    } ncd_state_t;

    typedef struct packed
    {
        logic signed [DIST_W-1:0]   dist_from;
        logic                       fin_from;
        logic signed [DIST_W-1:0]   dist_to;
        logic                       fin_to;
        logic signed [WEIGHT_W-1:0] weight;
    } relax_req_t;

    typedef struct packed
    {
        logic                     relax;
        logic signed [DIST_W-1:0] cand;
    } relax_rsp_t;

endpackage

// ===== hdl/ncd_if.sv =====
// ----------------------------------------------------------------------------
// ncd_if
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
interface ncd_in_if
    import ncd_pkg::*;
();
    logic                       valid;
    logic                       ready;
    op_t                        opcode;
    logic [FIELD_NODE_W-1:0]    from_node;
    logic [FIELD_NODE_W-1:0]    to_node;
    logic signed [WEIGHT_W-1:0] edge_weight;

    modport source (output valid, opcode, from_node, to_node, edge_weight, input ready);
    modport sink   (input valid, opcode, from_node, to_node, edge_weight, output ready);
endinterface

interface ncd_out_if
    import ncd_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic                    found;
    logic [FIELD_NODE_W-1:0] cycle_node;
    logic                    last_node;

    modport source (output valid, found, cycle_node, last_node, input ready);
    modport sink   (input valid, found, cycle_node, last_node, output ready);
endinterface

// ===== hdl/negative_cycle_detector_top.sv =====
// ----------------------------------------------------------------------------
// negative_cycle_detector_top
// Bellman-Ford negative cycle search over a dense weight matrix.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     payload
//  items     in   valid/ready   opcode, from_node, to_node, edge_weight
//  results   out  valid/ready   found, cycle_node, last_node
//  cfg       in   cfg_we        cfg_wdata (nodes_in_use)
//
//  A load writes one weight into the matrix. A run relaxes every edge in repeated passes, one
//  edge per cycle through the shared add/compare unit, with a step per row to fetch the source
//  distance; then come the check pass, the predecessor walk and one emission per result.
//  items.ready is low for the whole run; a stalled results channel holds emission in
//  the output register. Reset is asynchronous, active low; weights undefined until loaded.
// ----------------------------------------------------------------------------
module negative_cycle_detector_top
    import ncd_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    ncd_in_if.sink           items,
    ncd_out_if.source        results,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int ADDR_W = $clog2(MAX_NODES * MAX_NODES);

    logic [CFG_W-1:0] nodes_reg;
    logic [CNT_W-1:0] node_count;

    logic              idle, start, load_we;
    logic [ADDR_W-1:0] waddr, raddr;
    logic signed [WEIGHT_W-1:0] rdata;
    relax_req_t        relax_req;
    relax_rsp_t        relax_rsp;

    logic                    emit_free, emit_valid, emit_found, emit_last;
    logic [FIELD_NODE_W-1:0] emit_node;

    logic                    out_valid_reg, found_reg, last_reg;
    logic [FIELD_NODE_W-1:0] node_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_reg <= NODES_RESET;
        end
        else if (cfg_we)
        begin
            nodes_reg <= cfg_wdata;
        end
    end

    // node count clamps to the range 2 .. MAX_NODES
    always_comb
    begin
        if (nodes_reg < CFG_W'(2))
        begin
            node_count = CNT_W'(2);
        end
        else if (32'(nodes_reg) > MAX_NODES)
        begin
            node_count = CNT_W'(MAX_NODES);
        end
        else
        begin
            node_count = CNT_W'(nodes_reg);
        end
    end

    assign items.ready = idle;
    assign start   = items.valid && idle && (items.opcode == OP_RUN);
    assign load_we = items.valid && idle && (items.opcode == OP_LOAD)
                     && (32'(items.from_node) < MAX_NODES)
                     && (32'(items.to_node) < MAX_NODES);
    assign waddr   = ADDR_W'(items.from_node) * ADDR_W'(MAX_NODES) + ADDR_W'(items.to_node);

    ncd_wmem #(.MAX_NODES(MAX_NODES)) u_wmem
    (
        .clk   (clk),
        .we    (load_we),
        .waddr (waddr),
        .wdata (items.edge_weight),
        .raddr (raddr),
        .rdata (rdata)
    );

    ncd_relax u_relax
    (
        .req (relax_req),
        .rsp (relax_rsp)
    );

    ncd_seq #(.MAX_NODES(MAX_NODES)) u_seq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .node_count (node_count),
        .idle       (idle),
        .mem_raddr  (raddr),
        .mem_rdata  (rdata),
        .relax_req  (relax_req),
        .relax_rsp  (relax_rsp),
        .emit_free  (emit_free),
        .emit_valid (emit_valid),
        .emit_found (emit_found),
        .emit_node  (emit_node),
        .emit_last  (emit_last)
    );

    assign emit_free = !out_valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid)
        begin
            found_reg <= emit_found;
            node_reg  <= emit_node;
            last_reg  <= emit_last;
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.found      = found_reg;
    assign results.cycle_node = node_reg;
    assign results.last_node  = last_reg;

    // a result is never produced while a new transaction could be taken
    a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid |-> !items.ready)
        else $error("result emitted while accepting items");

    // the output register is never overwritten while it still holds a result
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        emit_valid |-> emit_free)
        else $error("output register overwritten");

    // a run closes the input side on the next cycle
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> !items.ready)
        else $error("ready after run start");

    // a not-found result is always a single, final result on node zero
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.found) |-> (results.last_node && results.cycle_node == '0))
        else $error("malformed not-found result");

endmodule

// ===== hdl/ncd_wmem.sv =====
// ----------------------------------------------------------------------------
// ncd_wmem
// Edge weight matrix: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ncd_wmem
    import ncd_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [$clog2(MAX_NODES*MAX_NODES)-1:0]       waddr,
    input  logic signed [WEIGHT_W-1:0]                   wdata,
    input  logic [$clog2(MAX_NODES*MAX_NODES)-1:0]       raddr,
    output logic signed [WEIGHT_W-1:0]                   rdata
);

    localparam int DEPTH = MAX_NODES * MAX_NODES;

    logic signed [WEIGHT_W-1:0] mem_reg [DEPTH];
    logic signed [WEIGHT_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/ncd_relax.sv =====
// ----------------------------------------------------------------------------
// ncd_relax
// Shared relaxation unit: candidate distance and relax decision for one edge.
// ----------------------------------------------------------------------------
module ncd_relax
    import ncd_pkg::*;
(
    input  relax_req_t req,
    output relax_rsp_t rsp
);

    logic signed [DIST_W-1:0] cand;

    assign cand      = req.dist_from + DIST_W'(req.weight);
    // an unreached source never relaxes; an unreached target takes the candidate whenever the source is reached
    assign rsp.cand  = cand;
    assign rsp.relax = req.fin_from && (!req.fin_to || (req.dist_to > cand));

endmodule

// ===== hdl/ncd_seq.sv =====
// ----------------------------------------------------------------------------
// ncd_seq
// Sequencer: relaxation passes, final check pass, predecessor walk, emission.
// ----------------------------------------------------------------------------
module ncd_seq
    import ncd_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [$clog2(MAX_NODES+1)-1:0]         node_count,
    output logic                                   idle,
    output logic [$clog2(MAX_NODES*MAX_NODES)-1:0] mem_raddr,
    input  logic signed [WEIGHT_W-1:0]             mem_rdata,
    output relax_req_t                             relax_req,
    input  relax_rsp_t                             relax_rsp,
    input  logic                                   emit_free,
    output logic                                   emit_valid,
    output logic                                   emit_found,
    output logic [FIELD_NODE_W-1:0]                emit_node,
    output logic                                   emit_last
);

    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int ADDR_W    = $clog2(MAX_NODES * MAX_NODES);
    localparam int BUF_DEPTH = MAX_NODES + 1;
    localparam int BUF_W     = $clog2(BUF_DEPTH);
    localparam int LEN_W     = $clog2(BUF_DEPTH + 1);

    ncd_state_t state_reg, state_next;

    logic [CNT_W-1:0]         k_reg, k_next;
    logic [CNT_W-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic                     check_reg, check_next;
    logic [MAX_NODES-1:0]     fin_reg, fin_next;
    logic [MAX_NODES-1:0]     predv_reg, predv_next;
    logic [MAX_NODES-1:0]     seen_reg, seen_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [BUF_W-1:0]         emit_reg, emit_next;
    logic [NODE_W-1:0]        cur_reg, cur_next;
    logic                     fi_reg, fi_next;
    logic signed [DIST_W-1:0] di_reg, di_next;

    logic signed [DIST_W-1:0] dist_reg [MAX_NODES];
    logic signed [DIST_W-1:0] dist_next [MAX_NODES];
    logic [NODE_W-1:0]        pred_reg [MAX_NODES];
    logic [NODE_W-1:0]        pred_next [MAX_NODES];
    logic [NODE_W-1:0]        buf_reg [BUF_DEPTH];
    logic [NODE_W-1:0]        buf_next [BUF_DEPTH];

    logic [NODE_W-1:0] i_idx, j_idx, p_node;
    logic [CNT_W-1:0]  i_inc, j_inc, k_plus2;
    logic              last_i, last_j, last_k, walk_stop;

    assign i_idx   = i_reg[NODE_W-1:0];
    assign j_idx   = j_reg[NODE_W-1:0];
    assign i_inc   = i_reg + CNT_W'(1);
    assign j_inc   = j_reg + CNT_W'(1);
    assign k_plus2 = k_reg + CNT_W'(2);
    assign last_i  = (i_inc == node_count);
    assign last_j  = (j_inc == node_count);
    assign last_k  = (k_plus2 == node_count);
    assign p_node  = pred_reg[cur_reg];
    assign walk_stop = (len_reg == LEN_W'(BUF_DEPTH)) || !predv_reg[cur_reg];

    assign relax_req.dist_from = di_reg;
    assign relax_req.fin_from  = fi_reg;
    assign relax_req.dist_to   = dist_reg[j_idx];
    assign relax_req.fin_to    = fin_reg[j_idx];
    assign relax_req.weight    = mem_rdata;

    assign idle = (state_reg == ST_IDLE);

    // prefetch: in ROW the first weight of the row, in EDGE the next one
    always_comb
    begin
        if (state_reg == ST_ROW)
        begin
            mem_raddr = ADDR_W'(i_reg) * ADDR_W'(MAX_NODES);
        end
        else
        begin
            mem_raddr = ADDR_W'(i_reg) * ADDR_W'(MAX_NODES) + ADDR_W'(j_inc);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                state_next = ST_EDGE;
            end
            ST_EDGE:
            begin
                if (check_reg && relax_rsp.relax)
                begin
                    state_next = (i_idx == j_idx) ? ST_EMIT : ST_WALK;
                end
                else if (last_j)
                begin
                    if (last_i && check_reg)
                    begin
                        state_next = ST_NONE;
                    end
                    else
                    begin
                        state_next = ST_ROW;
                    end
                end
            end
            ST_WALK:
            begin
                if (walk_stop || seen_reg[p_node])
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_free && (emit_reg == '0))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_NONE:
            begin
                if (emit_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        k_next     = k_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        check_next = check_reg;
        fin_next   = fin_reg;
        predv_next = predv_reg;
        seen_next  = seen_reg;
        len_next   = len_reg;
        emit_next  = emit_reg;
        cur_next   = cur_reg;
        fi_next    = fi_reg;
        di_next    = di_reg;
        dist_next  = dist_reg;
        pred_next  = pred_reg;
        buf_next   = buf_reg;
        emit_valid = 1'b0;
        emit_found = 1'b0;
        emit_node  = '0;
        emit_last  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    for (int m = 0; m < MAX_NODES; m++)
                    begin
                        dist_next[m] = '0;
                    end
                    fin_next   = MAX_NODES'(1);
                    predv_next = '0;
                    k_next     = '0;
                    i_next     = '0;
                    j_next     = '0;
                    check_next = 1'b0;
                end
            end
            ST_ROW:
            begin
                di_next = dist_reg[i_idx];
                fi_next = fin_reg[i_idx];
                j_next  = '0;
            end
            ST_EDGE:
            begin
                if (check_reg && relax_rsp.relax)
                begin
                    buf_next[0] = j_idx;
                    buf_next[1] = i_idx;
                    len_next    = LEN_W'(2);
                    emit_next   = BUF_W'(1);
                    cur_next    = i_idx;
                    seen_next   = (MAX_NODES'(1) << i_idx) | (MAX_NODES'(1) << j_idx);
                end
                else
                begin
                    if (relax_rsp.relax)
                    begin
                        dist_next[j_idx] = relax_rsp.cand;
                        fin_next[j_idx]  = 1'b1;
                        pred_next[j_idx] = i_idx;
                        predv_next[j_idx] = 1'b1;
                        // self-loop updates the held source distance in place
                        if (j_idx == i_idx)
                        begin
                            di_next = relax_rsp.cand;
                        end
                    end
                    if (!last_j)
                    begin
                        j_next = j_inc;
                    end
                    else if (!last_i)
                    begin
                        i_next = i_inc;
                    end
                    else
                    begin
                        i_next = '0;
                        if (!check_reg)
                        begin
                            if (last_k)
                            begin
                                check_next = 1'b1;
                            end
                            else
                            begin
                                k_next = k_reg + CNT_W'(1);
                            end
                        end
                    end
                end
            end
            ST_WALK:
            begin
                if (walk_stop)
                begin
                    emit_next = BUF_W'(len_reg - LEN_W'(1));
                end
                else
                begin
                    buf_next[len_reg[BUF_W-1:0]] = p_node;
                    len_next  = len_reg + LEN_W'(1);
                    cur_next  = p_node;
                    seen_next = seen_reg | (MAX_NODES'(1) << p_node);
                    emit_next = BUF_W'(len_reg);
                end
            end
            ST_EMIT:
            begin
                if (emit_free)
                begin
                    emit_valid = 1'b1;
                    emit_found = 1'b1;
                    emit_node  = FIELD_NODE_W'(buf_reg[emit_reg]);
                    emit_last  = (emit_reg == '0);
                    if (emit_reg != '0)
                    begin
                        emit_next = emit_reg - BUF_W'(1);
                    end
                end
            end
            ST_NONE:
            begin
                if (emit_free)
                begin
                    emit_valid = 1'b1;
                    emit_last  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            check_reg <= 1'b0;
            fin_reg   <= MAX_NODES'(1);
            predv_reg <= '0;
            seen_reg  <= '0;
            len_reg   <= '0;
            emit_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            check_reg <= check_next;
            fin_reg   <= fin_next;
            predv_reg <= predv_next;
            seen_reg  <= seen_next;
            len_reg   <= len_next;
            emit_reg  <= emit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        fi_reg   <= fi_next;
        di_reg   <= di_next;
        dist_reg <= dist_next;
        pred_reg <= pred_next;
        buf_reg  <= buf_next;
    end

endmodule
